### rtl/core/frustum_cull_test_core_assert.svh
// Assertion macros shared by the frustum cull test core
`ifndef FRUSTUM_CULL_TEST_CORE_ASSERT_SVH
`define FRUSTUM_CULL_TEST_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define FCT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/fct_pkg.sv
// Package: constants, codes and types of the frustum cull test core
`default_nettype none

package fct_pkg;

  // Plane store geometry
  localparam int NUM_PLANES = 6;
  localparam int PIDX_W     = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  // Field widths
  localparam int CMD_W  = 3;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;

  // Arithmetic widths: 32x32 products, 33-bit offset term, 68-bit sums
  localparam int PROD_W = 2 * DATA_W;
  localparam int DK_W   = DATA_W + 1;
  localparam int SUM_W  = PROD_W + 4;
  localparam int FRAC_W = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POINT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SPHERE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CUBE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BOX    = 3'd4;

  // One plane: a*x + b*y + c*z + d
  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] d;
  } plane_t;

  // Plane store write request
  typedef struct packed {
    logic              en;
    logic [PIDX_W-1:0] addr;
    plane_t            plane;
  } plane_wr_t;

  // Operands of one test: centre, half extents (zero unless cube or box), radius
  typedef struct packed {
    logic signed [DATA_W-1:0] cx;
    logic signed [DATA_W-1:0] cy;
    logic signed [DATA_W-1:0] cz;
    logic signed [DATA_W-1:0] ex;
    logic signed [DATA_W-1:0] ey;
    logic signed [DATA_W-1:0] ez;
    logic signed [DATA_W-1:0] rad;
  } op_t;

  // Pipeline tag that travels with each plane read
  typedef struct packed {
    logic vld;
    logic last;
  } tag_t;

  // Per-plane outcome
  typedef struct packed {
    logic vld;
    logic last;
    logic neg;
  } dot_res_t;

endpackage

`default_nettype wire

### rtl/core/fct_in_if.sv
// Interface: input item channel of the frustum cull test core
`default_nettype none

interface fct_in_if import fct_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [IDX_W-1:0]         plane_index;
  logic signed [DATA_W-1:0] plane_a;
  logic signed [DATA_W-1:0] plane_b;
  logic signed [DATA_W-1:0] plane_c;
  logic signed [DATA_W-1:0] plane_d;
  logic signed [DATA_W-1:0] center_x;
  logic signed [DATA_W-1:0] center_y;
  logic signed [DATA_W-1:0] center_z;
  logic signed [DATA_W-1:0] size_x;
  logic signed [DATA_W-1:0] size_y;
  logic signed [DATA_W-1:0] size_z;

  modport source (
    output valid, command, plane_index, plane_a, plane_b, plane_c, plane_d,
           center_x, center_y, center_z, size_x, size_y, size_z,
    input  ready
  );

  modport sink (
    input  valid, command, plane_index, plane_a, plane_b, plane_c, plane_d,
           center_x, center_y, center_z, size_x, size_y, size_z,
    output ready
  );

endinterface

`default_nettype wire

### rtl/core/fct_out_if.sv
// Interface: result channel of the frustum cull test core
`default_nettype none

interface fct_out_if import fct_pkg::*; ();

  logic             valid;
  logic             ready;
  logic             visible;
  logic [CMD_W-1:0] test_kind;

  modport source (
    output valid, visible, test_kind,
    input  ready
  );

  modport sink (
    input  valid, visible, test_kind,
    output ready
  );

endinterface

`default_nettype wire

### rtl/core/fct_plane_mem.sv
// Plane store: synchronous memory with registered read and per-entry valid bits
`default_nettype none

module fct_plane_mem import fct_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire plane_wr_t         wr,
  input  wire logic              rd_en,
  input  wire logic [PIDX_W-1:0] rd_addr,
  output      plane_t            rd_data
);

  plane_t                mem_r [NUM_PLANES];
  logic [NUM_PLANES-1:0] vld_r;
  plane_t                rd_data_r;

  // Write an entry; the payload array has no reset
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.plane;
    end
  end

  // Mark written entries; reset makes every entry read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Register the read data; an unwritten entry reads as its reset value
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem_r[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/core/fct_dot_unit.sv
// Plane dot unit: three-stage pipeline that gives the sign of the best-case dot
`default_nettype none

module fct_dot_unit import fct_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire tag_t     tag_in,
  input  wire plane_t   plane_in,
  input  wire op_t      op_in,
  output      dot_res_t res_out
);

  // Magnitude of a signed product at sum width
  function automatic logic signed [SUM_W-1:0] mag(input logic signed [PROD_W-1:0] v);
    logic signed [SUM_W-1:0] w;
    w = SUM_W'(v);
    return v[PROD_W-1] ? -w : w;
  endfunction

  tag_t                     tag1_r, tag2_r;
  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r;
  logic signed [PROD_W-1:0] q0_r, q1_r, q2_r;
  logic signed [DK_W-1:0]   dk_r;
  logic signed [SUM_W-1:0]  sa_r, sb_r;
  logic signed [SUM_W-1:0]  total;
  dot_res_t                 res_r;

  // Stage 1: centre products, extent products and offset term.
  // The corner nearest the positive side adds |coef*extent| on every axis,
  // so the extent terms are zero for point and sphere tests.
  always_ff @(posedge clk) begin
    p0_r <= PROD_W'(plane_in.a) * PROD_W'(op_in.cx);
    p1_r <= PROD_W'(plane_in.b) * PROD_W'(op_in.cy);
    p2_r <= PROD_W'(plane_in.c) * PROD_W'(op_in.cz);
    q0_r <= PROD_W'(plane_in.a) * PROD_W'(op_in.ex);
    q1_r <= PROD_W'(plane_in.b) * PROD_W'(op_in.ey);
    q2_r <= PROD_W'(plane_in.c) * PROD_W'(op_in.ez);
    dk_r <= DK_W'(plane_in.d) + DK_W'(op_in.rad);
  end

  // Stage 2: partial sums
  always_ff @(posedge clk) begin
    sa_r <= SUM_W'(p0_r) + SUM_W'(p1_r) + SUM_W'(p2_r);
    sb_r <= mag(q0_r) + mag(q1_r) + mag(q2_r) + (SUM_W'(dk_r) <<< FRAC_W);
  end

  // Stage 3: final sum, keep only its sign
  assign total = sa_r + sb_r;

  // Advance tags alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      res_r  <= '0;
    end else begin
      tag1_r     <= tag_in;
      tag2_r     <= tag1_r;
      res_r.vld  <= tag2_r.vld;
      res_r.last <= tag2_r.last;
      res_r.neg  <= total[SUM_W-1];
    end
  end

  assign res_out = res_r;

endmodule

`default_nettype wire

### rtl/core/frustum_cull_test_core.sv
// Top level: sequencer, plane store and dot pipeline of the frustum cull test core
//
// Usage:
//   in_ch carries one item per transfer. A load (command 0) writes one plane
//   into the store in the transfer cycle and gives no result; a load to a slot
//   at or beyond the plane count and commands 5 to 7 are taken and dropped.
//   A point, sphere, cube or box test gives one transfer on out_ch with the
//   visible flag and the command echoed in test_kind.
//   A test reads one plane per cycle from the store; each read feeds a
//   three-stage dot pipeline after the registered memory read. Its result is
//   in the output register once the last outcome has passed the drain and done
//   states, and in_ch accepts the next item in that same cycle; in_ch takes no
//   item while a test runs, and takes loads every cycle while idle.
//   The output register holds a result while out_ch stalls; in_ch keeps taking
//   items meanwhile, and a finished test waits for the register to free up.
//   Reset empties the output register and marks every plane as zero.
`default_nettype none

`include "frustum_cull_test_core_assert.svh"

module frustum_cull_test_core import fct_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  fct_in_if.sink   in_ch,
  fct_out_if.source out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [PIDX_W-1:0] cnt_r, cnt_nxt;
  logic              rej_r, rej_nxt;
  op_t               op_r;
  logic [CMD_W-1:0]  kind_r;
  tag_t              tag_r;
  logic              out_valid_r;
  logic              vis_out_r;
  logic [CMD_W-1:0]  kind_out_r;

  logic       in_xfer;
  logic       is_test;
  logic       cnt_last;
  logic       out_free;
  logic       out_load;
  plane_wr_t  wr;
  logic       rd_en;
  plane_t     rd_data;
  op_t        op_nxt;
  dot_res_t   dres;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid & in_ch.ready;
  assign is_test     = in_ch.command inside {[CMD_POINT:CMD_BOX]};
  assign cnt_last    = (cnt_r == PIDX_W'(NUM_PLANES - 1));
  assign out_free    = !out_valid_r || out_ch.ready;
  assign out_load    = (state_r == ST_DONE) && out_free;
  assign rd_en       = (state_r == ST_ISSUE);

  // Plane load request, dropped when the slot is out of range
  always_comb begin
    wr.en      = in_xfer && (in_ch.command == CMD_LOAD) &&
                 ({1'b0, in_ch.plane_index} < (IDX_W + 1)'(NUM_PLANES));
    wr.addr    = in_ch.plane_index[PIDX_W-1:0];
    wr.plane.a = in_ch.plane_a;
    wr.plane.b = in_ch.plane_b;
    wr.plane.c = in_ch.plane_c;
    wr.plane.d = in_ch.plane_d;
  end

  // Test operands: a cube uses size_x on every axis, a sphere adds its radius
  always_comb begin
    op_nxt.cx  = in_ch.center_x;
    op_nxt.cy  = in_ch.center_y;
    op_nxt.cz  = in_ch.center_z;
    op_nxt.ex  = '0;
    op_nxt.ey  = '0;
    op_nxt.ez  = '0;
    op_nxt.rad = '0;
    case (in_ch.command)
      CMD_SPHERE: begin
        op_nxt.rad = in_ch.size_x;
      end
      CMD_CUBE: begin
        op_nxt.ex = in_ch.size_x;
        op_nxt.ey = in_ch.size_x;
        op_nxt.ez = in_ch.size_x;
      end
      CMD_BOX: begin
        op_nxt.ex = in_ch.size_x;
        op_nxt.ey = in_ch.size_y;
        op_nxt.ez = in_ch.size_z;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: issue one plane read per cycle, drain, then post the result
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rej_nxt   = rej_r;
    if (dres.vld) begin
      rej_nxt = rej_r | dres.neg;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && is_test) begin
          state_nxt = ST_ISSUE;
          cnt_nxt   = '0;
          rej_nxt   = 1'b0;
        end
      end
      ST_ISSUE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dres.vld && dres.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      rej_r   <= 1'b0;
      tag_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rej_r     <= rej_nxt;
      tag_r.vld <= rd_en;
      tag_r.last <= rd_en && cnt_last;
    end
  end

  // Hold test operands for the whole pass
  always_ff @(posedge clk) begin
    if (in_xfer && is_test) begin
      op_r   <= op_nxt;
      kind_r <= in_ch.command;
    end
  end

  // Output register: load on completion, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      vis_out_r  <= !rej_r;
      kind_out_r <= kind_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.visible   = vis_out_r;
  assign out_ch.test_kind = kind_out_r;

  fct_plane_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (cnt_r),
    .rd_data (rd_data)
  );

  fct_dot_unit u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (tag_r),
    .plane_in (rd_data),
    .op_in    (op_r),
    .res_out  (dres)
  );

  // Checks
  `FCT_ASSERT_SAME(a_cnt_range, state_r == ST_ISSUE, cnt_r <= PIDX_W'(NUM_PLANES - 1),
                   "plane counter beyond the store")
  `FCT_ASSERT_SAME(a_res_when_busy, dres.vld, state_r == ST_ISSUE || state_r == ST_DRAIN,
                   "plane outcome outside a test pass")
  `FCT_ASSERT_NEXT(a_test_starts, in_xfer && is_test, state_r == ST_ISSUE && cnt_r == '0,
                   "test transfer did not start a pass")

endmodule

`default_nettype wire
